[sv/csvd_pkg.sv]
// package for the compressed stream version detector
// request and response payload types, magic words, status codes and header tables
// no dependencies
`default_nettype none

package csvd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  major;
      logic [7:0]  minor;
      logic [7:0]  patch;
      logic [31:0] version_word;
   } rsp_type;

   localparam logic [1:0] STATUS_SHORT  = 2'd0;
   localparam logic [1:0] STATUS_TAGGED = 2'd1;
   localparam logic [1:0] STATUS_L302   = 2'd2;
   localparam logic [1:0] STATUS_L317   = 2'd3;

   localparam logic [31:0] TAG_MAGIC   = 32'hF342F310;
   localparam logic [31:0] FRAME_MAGIC = 32'hFD2FB528;

   localparam int unsigned POS_TAG_END  = 3;
   localparam int unsigned POS_VER_END  = 7;
   localparam int unsigned POS_ZSTD_END = 11;
   localparam int unsigned POS_DESC     = 12;
   localparam int unsigned MIN_LEN      = 12;
   localparam int unsigned FRAME_BASE   = 8;

   function automatic logic [3:0] fcs_len(input logic [1:0] code);
      logic [3:0] len;
      unique case (code)
         2'd0: len = 4'd0;
         2'd1: len = 4'd2;
         2'd2: len = 4'd4;
         default: len = 4'd8;
      endcase
      return len;
   endfunction

   function automatic logic [2:0] dict_len(input logic [1:0] code);
      logic [2:0] len;
      unique case (code)
         2'd0: len = 3'd0;
         2'd1: len = 3'd1;
         2'd2: len = 3'd2;
         default: len = 3'd4;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[sv/csvd_scan.sv]
// frame scanner: byte counter, magic detection, header decode and block walk
// produces the response for the final byte of a buffer; uses csvd_pkg
`default_nettype none

module csvd_scan #(
   parameter int LEN_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire csvd_pkg::req_type in_data,
   output csvd_pkg::rsp_type     result
);
   import csvd_pkg::*;

   localparam int SUM_W = ((LEN_BITS > 22) ? LEN_BITS : 22) + 1;
   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   logic [LEN_BITS-1:0] bc_ff, bc_in;
   logic [31:0]         ws_ff, ws_in;
   logic                tag_ff, tag_in;
   logic [31:0]         ver_ff, ver_in;
   logic                zstd_ff, zstd_in;
   logic [7:0]          desc_ff, desc_in;
   logic [LEN_BITS-1:0] nbs_ff, nbs_in;
   logic [23:0]         bhs_ff, bhs_in;
   logic [1:0]          hbs_ff, hbs_in;
   logic                final_ff, final_in;
   logic                trunc_ff, trunc_in;
   logic [LEN_BITS-1:0] fe_ff, fe_in;

   logic [7:0]          b;
   logic                take;
   logic [4:0]          hs_pos;
   logic [23:0]         bhs_new;
   logic [SUM_W-1:0]    blk_sum;
   logic [SUM_W-1:0]    blk_sum_cks;
   logic                flush;

   function automatic logic [LEN_BITS-1:0] sat(input logic [SUM_W-1:0] x);
      return (x > SUM_W'(LEN_MAX)) ? LEN_MAX : x[LEN_BITS-1:0];
   endfunction

   assign b       = in_data.data_byte;
   assign take    = advance && (bc_ff != LEN_MAX);
   assign flush   = advance && in_data.last_byte;
   assign bhs_new = {b, bhs_ff[23:8]};

   // frame base plus header size from the descriptor byte
   assign hs_pos = 5'(FRAME_BASE) + 5'd5 + {4'd0, ~b[5]} + {2'd0, dict_len(b[1:0])} +
                   (((b[7:6] == 2'd0) && b[5]) ? 5'd1 : {1'b0, fcs_len(b[7:6])});

   assign blk_sum     = SUM_W'(nbs_ff) + SUM_W'(3) + SUM_W'(bhs_new[23:3]);
   assign blk_sum_cks = blk_sum + (desc_ff[2] ? SUM_W'(4) : SUM_W'(0));

   always_comb begin
      bc_in    = bc_ff;
      ws_in    = ws_ff;
      tag_in   = tag_ff;
      ver_in   = ver_ff;
      zstd_in  = zstd_ff;
      desc_in  = desc_ff;
      nbs_in   = nbs_ff;
      bhs_in   = bhs_ff;
      hbs_in   = hbs_ff;
      final_in = final_ff;
      trunc_in = trunc_ff;
      fe_in    = fe_ff;
      if (take) begin
         bc_in = bc_ff + LEN_BITS'(1);
         if (bc_ff == LEN_MAX - LEN_BITS'(1)) begin
            trunc_in = 1'b1;
         end
         ws_in = {b, ws_ff[31:8]};
         if (bc_ff == LEN_BITS'(POS_TAG_END)) begin
            tag_in = (ws_in == TAG_MAGIC);
         end else if (bc_ff == LEN_BITS'(POS_VER_END)) begin
            ver_in = ws_in;
         end else if (bc_ff == LEN_BITS'(POS_ZSTD_END)) begin
            zstd_in = !tag_ff && (ws_in == FRAME_MAGIC);
         end else if (bc_ff == LEN_BITS'(POS_DESC)) begin
            desc_in = b;
            nbs_in  = LEN_BITS'(hs_pos);
            fe_in   = LEN_BITS'(hs_pos) + (b[2] ? LEN_BITS'(4) : LEN_BITS'(0));
         end else if ((bc_ff > LEN_BITS'(POS_DESC)) && zstd_ff && !final_ff) begin
            if ((hbs_ff != 2'd0) || (bc_ff == nbs_ff)) begin
               bhs_in = bhs_new;
               if (hbs_ff == 2'd2) begin
                  hbs_in   = 2'd0;
                  final_in = final_ff | bhs_new[0];
                  nbs_in   = sat(blk_sum);
                  fe_in    = sat(blk_sum_cks);
               end else begin
                  hbs_in = hbs_ff + 2'd1;
               end
            end
         end
      end
   end

   always_comb begin
      result = '0;
      if (bc_in < LEN_BITS'(MIN_LEN)) begin
         result.status = STATUS_SHORT;
      end else if (tag_in) begin
         result.status       = STATUS_TAGGED;
         result.major        = ver_in[31:24];
         result.minor        = ver_in[23:16];
         result.patch        = ver_in[15:8];
         result.version_word = ver_in;
      end else if (!zstd_in || (bc_in == LEN_BITS'(MIN_LEN)) || trunc_in ||
                   (hbs_in != 2'd0)) begin
         result.status = STATUS_L317;
      end else begin
         result.status = (fe_in == bc_in) ? STATUS_L302 : STATUS_L317;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         bc_ff    <= '0;
         ws_ff    <= '0;
         tag_ff   <= 1'b0;
         ver_ff   <= '0;
         zstd_ff  <= 1'b0;
         desc_ff  <= '0;
         nbs_ff   <= '0;
         bhs_ff   <= '0;
         hbs_ff   <= '0;
         final_ff <= 1'b0;
         trunc_ff <= 1'b0;
         fe_ff    <= '0;
      end else begin
         bc_ff    <= bc_in;
         ws_ff    <= ws_in;
         tag_ff   <= tag_in;
         ver_ff   <= ver_in;
         zstd_ff  <= zstd_in;
         desc_ff  <= desc_in;
         nbs_ff   <= nbs_in;
         bhs_ff   <= bhs_in;
         hbs_ff   <= hbs_in;
         final_ff <= final_in;
         trunc_ff <= trunc_in;
         fe_ff    <= fe_in;
      end
   end

   a_hbs_range: assert property (@(posedge clock) disable iff (reset)
      hbs_ff != 2'd3)
      else $error("block header byte count out of range");

   a_final_needs_zstd: assert property (@(posedge clock) disable iff (reset)
      final_ff |-> zstd_ff)
      else $error("final block seen without zstd magic");

   a_magic_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(tag_ff && zstd_ff))
      else $error("tagged and zstd magic both set");

   a_trunc_saturated: assert property (@(posedge clock) disable iff (reset)
      trunc_ff |-> (bc_ff == LEN_MAX))
      else $error("truncation flag without saturated count");

endmodule

`default_nettype wire

[sv/csvd_rsp_reg.sv]
// response output register with valid/ready handshake
// holds one response until taken; uses csvd_pkg
`default_nettype none

module csvd_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire csvd_pkg::rsp_type load_data,
   output logic                   can_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output csvd_pkg::rsp_type      rsp_data
);
   import csvd_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign can_take  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

[sv/compressed_stream_version_detector.sv]
// compressed stream version detector: top level
// input register, frame scanner and response register; uses csvd_pkg,
// csvd_scan and csvd_rsp_reg
//
// the req channel carries one byte of a compressed buffer per request, with
// last_byte set on the final byte. requests are taken while req_ready is
// high; only the final byte of a buffer yields a response on the rsp
// channel, carrying status and, for the tagged format, the version bytes
// and word. throughput is one byte per cycle while req_ready is high, as
// the scanner updates its state on every accepted byte. a final byte sits
// in the input register until the response register can take it; then the
// scanner result is loaded into the response register, raising rsp_valid.
// when the receiver stalls, non-final bytes keep flowing; a final byte waits
// in the input register until the response register frees, and req_ready
// drops while it waits.
// synchronous reset clears the input and response valid flags and all
// scanner state; after each response the scanner returns to its reset state
// so the next byte starts a new buffer.
// buffers of 2^LEN_BITS-1 bytes or more saturate the byte counter.
`default_nettype none

module compressed_stream_version_detector #(
   parameter int LEN_BITS = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire csvd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output csvd_pkg::rsp_type      rsp_data
);
   import csvd_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    advance;
   logic    can_take;
   rsp_type result;

   assign advance   = in_valid_ff && (!in_data_ff.last_byte || can_take);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   csvd_scan #(
      .LEN_BITS(LEN_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .in_data(in_data_ff),
      .result (result)
   );

   csvd_rsp_reg u_rsp (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && in_data_ff.last_byte),
      .load_data(result),
      .can_take (can_take),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
